@@ rtl/hac_pkg.sv @@
// shared types, codes and helper functions for the hex/raw/binary text converter
package hac_pkg;

    localparam int CHAR_W      = 8;
    localparam int FMT_W       = 2;
    localparam int CFG_NUM     = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int POS_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    // format register codes
    localparam logic [FMT_W-1:0] FMT_HEX = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RAW = 2'd1;
    localparam logic [FMT_W-1:0] FMT_BIN = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_FORMAT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_FORMAT = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] CH_END   = 8'h24;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] HEX_HIGH = 8'h37;  // 'A' - 10

    // how the back end expands one byte
    typedef enum logic [1:0] {
        MODE_SINGLE,
        MODE_HEX,
        MODE_BIN
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [CHAR_W-1:0] data;
    } job_t;

    // format value 3 acts as raw
    function automatic logic [FMT_W-1:0] norm_format(input logic [FMT_W-1:0] f);
        logic [FMT_W-1:0] r;
        r = (f == 2'd3) ? FMT_RAW : f;
        return r;
    endfunction

    function automatic mode_t fmt_mode(input logic [FMT_W-1:0] f);
        mode_t m;
        unique case (f)
            FMT_HEX: m = MODE_HEX;
            FMT_BIN: m = MODE_BIN;
            default: m = MODE_SINGLE;
        endcase
        return m;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        if (c >= CH_UP_A && c <= CH_UP_F)
            v = c - HEX_HIGH;
        else
            v = c - CH_ZERO;
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] ch;
        if (nib < 4'd10)
            ch = CH_ZERO + {4'd0, nib};
        else
            ch = HEX_HIGH + {4'd0, nib};
        return ch;
    endfunction

endpackage

@@ rtl/hex_ascii_binary_text_converter.sv @@
// top level of the hex/raw/binary text converter
//
// input channel: in_valid/in_stall/in_char, one character code per transfer.
// output channel: out_valid/out_stall/out_char/last_of_run, one character per
//   transfer; last_of_run marks the final character caused by an input item.
// config: cfg_we with cfg_index 0 (input_format) or 1 (output_format) and
//   cfg_data; formats are 0 hex, 1 raw, 2 binary (3 acts as raw). write only
//   while no item is in flight.
// path: a result passes through the job queue, then the output register, after
//   the input transfer that completes its byte.
// throughput: the front end takes one character per cycle while the job
//   queue has room; the back end emits one character per cycle while the
//   receiver does not stall, and an item yields one character (raw, echo, '$'),
//   two (hex output) or eight (binary output). that serializer sets the rate.
// CR and LF are dropped; '$' clears the packing state and emits a line feed.
// reset: formats go to hex, packing state clears, queue and output empty.
// when the receiver stalls, the output register holds its character, the back
//   end stops, and once the queue fills in_stall rises.
module hex_ascii_binary_text_converter
    import hac_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FMT_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CHAR_W-1:0]    in_char,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CHAR_W-1:0]    out_char,
    output logic                 last_of_run
);

    // jobs from the front end into the queue
    logic push;
    job_t push_job;
    logic q_full;

    // head of the queue toward the back end
    logic head_valid;
    job_t head_job;
    logic pop;

    hac_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_char   (in_char),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    hac_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // serializer with its own output register
    hac_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

endmodule

@@ rtl/hac_front.sv @@
// front end: config registers, character classification and byte packing
module hac_front
    import hac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FMT_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CHAR_W-1:0]    in_char,
    input  logic                 q_full,
    output logic                 push,
    output job_t                 push_job
);

    logic [FMT_W-1:0]  in_fmt_reg;
    logic [FMT_W-1:0]  out_fmt_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CHAR_W-1:0] packed_reg, packed_next;

    logic [FMT_W-1:0]  fi, fo;
    logic              accept;
    logic [CHAR_W-1:0] hex_byte;
    logic [CHAR_W-1:0] bin_mask;
    logic [CHAR_W-1:0] bin_byte;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign fi       = norm_format(in_fmt_reg);
    assign fo       = norm_format(out_fmt_reg);
    assign hex_byte = {packed_reg[3:0], 4'd0} + hex_value(in_char);
    assign bin_mask = 8'h80 >> pos_reg;
    assign bin_byte = (in_char == CH_ONE) ? (packed_reg | bin_mask) : packed_reg;

    always_comb
    begin
        push        = 1'b0;
        push_job    = '{mode: MODE_SINGLE, data: in_char};
        pos_next    = pos_reg;
        packed_next = packed_reg;
        if (accept)
        begin
            if (in_char == CH_CR || in_char == CH_LF)
            begin
                push = 1'b0;
            end
            else if (in_char == CH_END)
            begin
                push        = 1'b1;
                push_job    = '{mode: MODE_SINGLE, data: CH_LF};
                pos_next    = '0;
                packed_next = '0;
            end
            else if (fi == fo)
            begin
                push = 1'b1;
            end
            else if (fi == FMT_HEX)
            begin
                if (pos_reg == '0)
                begin
                    packed_next = hex_value(in_char);
                    pos_next    = POS_W'(1);
                end
                else
                begin
                    push        = 1'b1;
                    push_job    = '{mode: fmt_mode(fo), data: hex_byte};
                    pos_next    = '0;
                    packed_next = '0;
                end
            end
            else if (fi == FMT_BIN)
            begin
                if (pos_reg != '1)
                begin
                    packed_next = bin_byte;
                    pos_next    = pos_reg + POS_W'(1);
                end
                else
                begin
                    push        = 1'b1;
                    push_job    = '{mode: fmt_mode(fo), data: bin_byte};
                    pos_next    = '0;
                    packed_next = '0;
                end
            end
            else
            begin
                // raw input, packing state untouched
                push     = 1'b1;
                push_job = '{mode: fmt_mode(fo), data: in_char};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fmt_reg  <= FMT_HEX;
            out_fmt_reg <= FMT_HEX;
            pos_reg     <= '0;
            packed_reg  <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            packed_reg <= packed_next;
            if (cfg_we && cfg_index == CFG_INPUT_FORMAT)
                in_fmt_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_OUTPUT_FORMAT)
                out_fmt_reg <= cfg_data;
        end
    end

endmodule

@@ rtl/hac_queue.sv @@
// short job queue between front end and back end
module hac_queue
    import hac_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_job;
    end

endmodule

@@ rtl/hac_back.sv @@
// back end: expands one byte job into characters through an output register
module hac_back
    import hac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  job_t              head_job,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAR_W-1:0] out_char,
    output logic              last_of_run
);

    logic              busy_reg, busy_next;
    job_t              job_reg, job_next;
    logic [POS_W-1:0]  idx_reg, idx_next;
    logic              ov_reg, ov_next;
    logic [CHAR_W-1:0] oc_reg, oc_next;
    logic              ol_reg, ol_next;

    job_t              cur;
    logic              cur_valid;
    logic              advance;
    logic [CHAR_W-1:0] cur_char;
    logic              cur_last;
    logic [3:0]        nib;
    logic              bit_val;

    assign cur       = busy_reg ? job_reg : head_job;
    assign cur_valid = busy_reg || head_valid;
    assign advance   = !ov_reg || !out_stall;
    assign pop       = advance && !busy_reg && head_valid;
    assign nib       = idx_reg[0] ? cur.data[3:0] : cur.data[7:4];
    assign bit_val   = cur.data[3'd7 - idx_reg];

    always_comb
    begin
        unique case (cur.mode)
            MODE_HEX:
            begin
                cur_char = hex_char(nib);
                cur_last = idx_reg[0];
            end
            MODE_BIN:
            begin
                cur_char = bit_val ? CH_ONE : CH_ZERO;
                cur_last = (idx_reg == '1);
            end
            default:
            begin
                cur_char = cur.data;
                cur_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        job_next  = job_reg;
        idx_next  = idx_reg;
        ov_next   = ov_reg;
        oc_next   = oc_reg;
        ol_next   = ol_reg;
        if (advance)
        begin
            ov_next = cur_valid;
            if (cur_valid)
            begin
                oc_next = cur_char;
                ol_next = cur_last;
                job_next = cur;
                if (cur_last)
                begin
                    busy_next = 1'b0;
                    idx_next  = '0;
                end
                else
                begin
                    busy_next = 1'b1;
                    idx_next  = idx_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        oc_reg  <= oc_next;
        ol_reg  <= ol_next;
    end

    assign out_valid   = ov_reg;
    assign out_char    = oc_reg;
    assign last_of_run = ol_reg;

endmodule

@@ rtl/hac_checker.sv @@
// port-level checks for the text converter, bound to the top level
module hac_checker
    import hac_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [CHAR_W-1:0]    out_char,
    input logic                 last_of_run
);

    // output register is empty while reset is held
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

    // a stalled character holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last_of_run))
        else $error("stalled output changed");

    // a run does not pause once started
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("gap inside a multi-character run");

    // only hex or binary expansion produces characters before the last one
    a_nonlast_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |->
            (out_char >= CH_ZERO && out_char <= 8'h39) ||
            (out_char >= CH_UP_A && out_char <= CH_UP_F))
        else $error("non-final character is not a digit");

endmodule

bind hex_ascii_binary_text_converter hac_checker u_hac_checker (.*);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the hex/raw/binary text converter
module tb_top;
    import hac_pkg::*;

    // format value 3 is accepted by the registers and behaves as raw
    localparam logic [FMT_W-1:0] FMT_ALT_RAW = 2'd3;

    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 16;   // front end plus output register, with margin
    localparam int HOLD_CYCLES  = 300;  // long receiver hold-off, fills the job queue
    localparam int PHASE_ITEMS  = 24;   // counted items per random phase
    localparam int NUM_PHASES   = 10;
    localparam longint TIMEOUT_NS = 4_000_000;

    // directed stimulus rows: either a register write or one character
    typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [FMT_W-1:0]     fmt;
        logic [CHAR_W-1:0]    ch;
        logic                 typed;  // single result typed in below, last_of_run set
        logic [CHAR_W-1:0]    want;
    } row_t;

    localparam int PLAN_LEN = 31;
    localparam row_t PLAN [PLAN_LEN] = '{
        // after reset both forms are hex, so characters echo
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     8'h00,  1'b1, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     8'hFF,  1'b1, 8'hFF},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     CH_END, 1'b1, CH_LF},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     CH_CR,  1'b0, 8'h00},
        // hex in, raw out: valid pair, digit outside 0-9/A-F, dropped LF
        '{ROW_CFG,  CFG_OUTPUT_FORMAT, FMT_RAW,     8'h00,  1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     "4",    1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     "1",    1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     "g",    1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     "F",    1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     CH_LF,  1'b0, 8'h00},
        // half a byte then message end: partial byte thrown away
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     "3",    1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     CH_END, 1'b1, CH_LF},
        // hex in, binary out: all ones
        '{ROW_CFG,  CFG_OUTPUT_FORMAT, FMT_BIN,     8'h00,  1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     "F",    1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     "F",    1'b0, 8'h00},
        // binary in, hex out: three bits, one of them a non-'1' digit
        '{ROW_CFG,  CFG_INPUT_FORMAT,  FMT_BIN,     8'h00,  1'b0, 8'h00},
        '{ROW_CFG,  CFG_OUTPUT_FORMAT, FMT_HEX,     8'h00,  1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     "1",    1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     "x",    1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     "1",    1'b0, 8'h00},
        // switch to hex in mid-byte: the next digit is taken as a second digit
        '{ROW_CFG,  CFG_INPUT_FORMAT,  FMT_HEX,     8'h00,  1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     "5",    1'b0, 8'h00},
        // format 3 on input and raw output count as equal forms
        '{ROW_CFG,  CFG_INPUT_FORMAT,  FMT_ALT_RAW, 8'h00,  1'b0, 8'h00},
        '{ROW_CFG,  CFG_OUTPUT_FORMAT, FMT_RAW,     8'h00,  1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     8'h80,  1'b1, 8'h80},
        // raw in, binary and hex out
        '{ROW_CFG,  CFG_INPUT_FORMAT,  FMT_RAW,     8'h00,  1'b0, 8'h00},
        '{ROW_CFG,  CFG_OUTPUT_FORMAT, FMT_BIN,     8'h00,  1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     8'hA5,  1'b0, 8'h00},
        '{ROW_CFG,  CFG_OUTPUT_FORMAT, FMT_HEX,     8'h00,  1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     8'h0F,  1'b0, 8'h00},
        '{ROW_CHAR, CFG_INPUT_FORMAT,  FMT_HEX,     CH_END, 1'b1, CH_LF}
    };

    // format pairs of the random phases, the extremes among them
    localparam logic [FMT_W-1:0] PHASE_IN [NUM_PHASES] = '{
        FMT_HEX, FMT_HEX, FMT_BIN, FMT_BIN, FMT_RAW,
        FMT_RAW, FMT_ALT_RAW, FMT_HEX, FMT_BIN, FMT_ALT_RAW
    };
    localparam logic [FMT_W-1:0] PHASE_OUT [NUM_PHASES] = '{
        FMT_RAW, FMT_BIN, FMT_HEX, FMT_RAW, FMT_HEX,
        FMT_BIN, FMT_BIN, FMT_HEX, FMT_ALT_RAW, FMT_HEX
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FMT_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [CHAR_W-1:0]    in_char;
    logic                 out_valid;
    logic                 out_stall;
    logic [CHAR_W-1:0]    out_char;
    logic                 last_of_run;

    // converter model state, mirrors the block
    logic [FMT_W-1:0]     fmt_in_r  = FMT_HEX;
    logic [FMT_W-1:0]     fmt_out_r = FMT_HEX;
    logic [POS_W-1:0]     digit_pos = '0;
    logic [CHAR_W-1:0]    byte_acc  = '0;

    // characters still owed by the block, oldest first
    logic [CHAR_W-1:0]    want_char [$];
    logic                 want_last [$];

    int                   err_cnt   = 0;
    int                   burst_left = 0;
    bit                   hold_arm  = 1'b0;

    hex_ascii_binary_text_converter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_char     (in_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // converter model
    // ---------------------------------------------------------------

    function automatic logic [FMT_W-1:0] fmt_fold(input logic [FMT_W-1:0] f);
        return (f == FMT_ALT_RAW) ? FMT_RAW : f;
    endfunction

    // digit value; anything outside A-F counts as code minus '0', wrapping
    function automatic logic [CHAR_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        if (c >= "A" && c <= "F")
            v = c - "A" + 8'd10;
        else
            v = c - CH_ZERO;
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] nibble_glyph(input logic [3:0] nib);
        logic [CHAR_W-1:0] g;
        if (nib < 4'd10)
            g = CH_ZERO + {4'd0, nib};
        else
            g = "A" + {4'd0, nib} - 8'd10;
        return g;
    endfunction

    task automatic owe(input logic [CHAR_W-1:0] ch, input logic last, input bit keep);
        if (keep)
        begin
            want_char.push_back(ch);
            want_last.push_back(last);
        end
    endtask

    task automatic expand_byte(input logic [CHAR_W-1:0] b, input logic [FMT_W-1:0] fo,
                               input bit keep);
        int k;
        if (fo == FMT_HEX)
        begin
            owe(nibble_glyph(b[7:4]), 1'b0, keep);
            owe(nibble_glyph(b[3:0]), 1'b1, keep);
        end
        else if (fo == FMT_BIN)
        begin
            for (k = 0; k < 8; k++)
                owe(b[7-k] ? CH_ONE : CH_ZERO, k == 7, keep);
        end
        else
            owe(b, 1'b1, keep);
    endtask

    // advance the model by one accepted character, owing what it produces
    task automatic convert_char(input logic [CHAR_W-1:0] c, input bit keep);
        logic [FMT_W-1:0]  fi;
        logic [FMT_W-1:0]  fo;
        logic [CHAR_W-1:0] b;
        logic [POS_W-1:0]  pos;
        fi = fmt_fold(fmt_in_r);
        fo = fmt_fold(fmt_out_r);
        if (c == CH_CR || c == CH_LF)
            return;
        if (c == CH_END)
        begin
            digit_pos = '0;
            byte_acc  = '0;
            owe(CH_LF, 1'b1, keep);
            return;
        end
        if (fi == fo)
        begin
            owe(c, 1'b1, keep);
            return;
        end
        if (fi == FMT_HEX)
        begin
            // any nonzero position means a first digit is waiting
            if (digit_pos == '0)
            begin
                byte_acc  = digit_value(c);
                digit_pos = 3'd1;
                return;
            end
            b = {byte_acc[3:0], 4'h0} + digit_value(c);
            digit_pos = '0;
            byte_acc  = '0;
            expand_byte(b, fo, keep);
        end
        else if (fi == FMT_BIN)
        begin
            pos = digit_pos;
            if (c == CH_ONE)
                byte_acc[3'd7 - pos] = 1'b1;
            if (pos != 3'd7)
            begin
                digit_pos = pos + 3'd1;
                return;
            end
            b = byte_acc;
            digit_pos = '0;
            byte_acc  = '0;
            expand_byte(b, fo, keep);
        end
        else
            expand_byte(c, fo, keep);
    endtask

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // offer one character and hold it until the transfer happens
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic typed,
                             input logic [CHAR_W-1:0] typed_want);
        in_valid <= 1'b1;
        in_char  <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // transfer at this edge
        convert_char(c, !typed);
        if (typed)
            owe(typed_want, 1'b1, 1'b1);
    endtask

    // bursts of random length, random gaps between them
    task automatic pace();
        int gap;
        if (burst_left != 0)
            burst_left--;
        else
        begin
            gap        = $urandom_range(1, 9);
            burst_left = $urandom_range(0, 15);
            in_valid  <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // registers only change while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FMT_W-1:0] val);
        if (in_valid)
            in_valid <= 1'b0;
        while (want_char.size() != 0)
            @(posedge clk);
        // items that cause no result may still be in the front end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_INPUT_FORMAT)
            fmt_in_r = val;
        else
            fmt_out_r = val;
    endtask

    // mostly well-formed digits for the input form, some noise, line ends and message ends
    function automatic logic [CHAR_W-1:0] pick_char(input logic [FMT_W-1:0] fi);
        int r;
        logic [CHAR_W-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 4)
            c = CH_END;
        else if (r < 8)
            c = ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
        else if (r < 18 || fi == FMT_RAW)
            c = CHAR_W'($urandom_range(0, 255));
        else if (fi == FMT_HEX)
            c = nibble_glyph(4'($urandom_range(0, 15)));
        else
            c = ($urandom_range(0, 1) != 0) ? CH_ONE : CH_ZERO;
        return c;
    endfunction

    initial
    begin
        int i;
        int ph;
        int n;
        logic [CHAR_W-1:0] c;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_INPUT_FORMAT;
        cfg_data  = FMT_HEX;
        in_valid  = 1'b0;
        in_char   = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < PLAN_LEN; i++)
        begin
            if (PLAN[i].kind == ROW_CFG)
                write_reg(PLAN[i].idx, PLAN[i].fmt);
            else
            begin
                send_char(PLAN[i].ch, PLAN[i].typed, PLAN[i].want);
                pace();
            end
        end

        // random phases
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_reg(CFG_INPUT_FORMAT, PHASE_IN[ph]);
            write_reg(CFG_OUTPUT_FORMAT, PHASE_OUT[ph]);
            // the receiver starts its long hold-off while this phase sends
            if (ph == 0)
                hold_arm = 1'b1;
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                c = pick_char(fmt_fold(PHASE_IN[ph]));
                send_char(c, 1'b0, '0);
                // dropped line ends do not count
                if (c != CH_CR && c != CH_LF)
                    n++;
                pace();
            end
        end

        if (in_valid)
            in_valid <= 1'b0;
        while (want_char.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------
    // receiver side
    // ---------------------------------------------------------------

    // stall in stretches: none, random, periodic; one long hold-off
    initial
    begin
        int mode;
        int len;
        int k;
        bit hold_done;
        hold_done = 1'b0;
        out_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_arm && !hold_done)
            begin
                // sender keeps offering, so the queue fills and in_stall rises
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            mode = $urandom_range(0, 2);
            len  = $urandom_range(10, 60);
            for (k = 0; k < len; k++)
            begin
                // start the hold-off as soon as it is armed
                if (hold_arm && !hold_done)
                    break;
                if (mode == 0)
                    out_stall <= 1'b0;
                else if (mode == 1)
                    out_stall <= ($urandom_range(0, 2) == 0);
                else
                    out_stall <= ((k % 4) == 3);
                @(posedge clk);
            end
        end
    end

    // compare each output transfer against the oldest owed character
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (want_char.size() == 0)
            begin
                $error("out_char: expected no transfer, got %02h", out_char);
                err_cnt++;
            end
            else
            begin
                if (out_char !== want_char[0])
                begin
                    $error("out_char: expected %02h, got %02h", want_char[0], out_char);
                    err_cnt++;
                end
                if (last_of_run !== want_last[0])
                begin
                    $error("last_of_run: expected %0b, got %0b", want_last[0], last_of_run);
                    err_cnt++;
                end
                void'(want_char.pop_front());
                void'(want_last.pop_front());
            end
        end
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
